### sv/hsd_pkg.sv
// Shared constants and decode functions for the Hamming SEC decoder.
// No dependencies; imported by hsd_pipe and hamming_sec_decoder.
package hsd_pkg;

   localparam int CodeW     = 63;  // codeword width, position k+1 in bit k
   localparam int DataW     = 57;  // data positions in a full-length codeword
   localparam int SynW      = 6;   // syndrome / length width
   localparam int MaxLenDef = 63;
   localparam int CsrDataW  = 32;
   localparam int CsrAddrW  = 3;

   // register indexes
   localparam logic [0:0] RegCodeLength = 1'b0;

   // keep only positions 1..len
   function automatic logic [CodeW-1:0] len_mask(input logic [SynW-1:0] len);
      logic [CodeW-1:0] m;
      for (int k = 0; k < CodeW; k++) begin
         m[k] = (SynW'(k) < len);
      end
      return m;
   endfunction

   // each syndrome bit is the parity over positions that have that bit set
   function automatic logic [SynW-1:0] calc_syndrome(input logic [CodeW-1:0] w);
      logic [SynW-1:0] s;
      logic [SynW-1:0] q;
      s = '0;
      for (int k = 0; k < CodeW; k++) begin
         q = SynW'(k + 1);
         for (int b = 0; b < SynW; b++) begin
            if (q[b]) begin
               s[b] = s[b] ^ w[k];
            end
         end
      end
      return s;
   endfunction

   // gather the non-power-of-two positions in ascending order (pure wiring)
   function automatic logic [DataW-1:0] pack_data(input logic [CodeW-1:0] w);
      logic [DataW-1:0] d;
      int n;
      int q;
      d = '0;
      n = 0;
      for (int k = 0; k < CodeW; k++) begin
         q = k + 1;
         if ((q & (q - 1)) != 0) begin
            d[n] = w[k];
            n = n + 1;
         end
      end
      return d;
   endfunction

endpackage

### sv/hsd_pipe.sv
// Three-stage decode pipeline: mask, syndrome, correct and pack.
// Depends on hsd_pkg.
module hsd_pipe
   import hsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [SynW-1:0]  code_len,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CodeW-1:0] req_codeword,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [DataW-1:0] rsp_data_bits,
   output logic [SynW-1:0]  rsp_syndrome,
   output logic             rsp_corrected,
   output logic             rsp_uncorrectable
);

   // stage valids
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   // stage payloads
   logic [CodeW-1:0] w1_ff, w1_in, w2_ff, w2_in;
   logic [SynW-1:0]  len1_ff, len2_ff;
   logic [SynW-1:0]  syn2_ff, syn2_in;
   logic [DataW-1:0] data3_ff, data3_in;
   logic [SynW-1:0]  syn3_ff;
   logic             corr3_ff, corr3_in, unc3_ff, unc3_in;
   logic [CodeW-1:0] flip;
   logic             rdy1, rdy2, rdy3;

   // a stage may load when empty or when it hands its word on
   assign rdy3      = !v3_ff || !rsp_stall;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   // stage 1: drop bits beyond the code length
   assign w1_in = req_codeword & len_mask(code_len);
   assign v1_in = rdy1 ? req_valid : v1_ff;

   // stage 2: syndrome over the masked word
   assign syn2_in = calc_syndrome(w1_ff);
   assign w2_in   = w1_ff;
   assign v2_in   = rdy2 ? v1_ff : v2_ff;

   // stage 3: flip the addressed position if it lies in the code, then pack
   always_comb begin
      for (int k = 0; k < CodeW; k++) begin
         flip[k] = (syn2_ff == SynW'(k + 1));
      end
      corr3_in = (syn2_ff != '0) && (syn2_ff <= len2_ff);
      unc3_in  = (syn2_ff != '0) && (syn2_ff > len2_ff);
      data3_in = pack_data(corr3_in ? (w2_ff ^ flip) : w2_ff);
   end
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // payload registers load only when their stage advances
   always_ff @(posedge clock) begin
      if (rdy1) begin
         w1_ff   <= w1_in;
         len1_ff <= code_len;
      end
      if (rdy2) begin
         w2_ff   <= w2_in;
         syn2_ff <= syn2_in;
         len2_ff <= len1_ff;
      end
      if (rdy3) begin
         data3_ff <= data3_in;
         syn3_ff  <= syn2_ff;
         corr3_ff <= corr3_in;
         unc3_ff  <= unc3_in;
      end
   end

   assign rsp_valid         = v3_ff;
   assign rsp_data_bits     = data3_ff;
   assign rsp_syndrome      = syn3_ff;
   assign rsp_corrected     = corr3_ff;
   assign rsp_uncorrectable = unc3_ff;

   // a word is never both repaired and flagged
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_corrected && rsp_uncorrectable))
      else $error("corrected and uncorrectable both set");

   // any flag implies a nonzero syndrome
   a_flag_needs_syn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_corrected || rsp_uncorrectable) |-> rsp_syndrome != '0)
      else $error("flag raised with zero syndrome");

   // zero syndrome always ends up with no flag
   a_syn_zero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_syndrome == '0 |-> !rsp_corrected && !rsp_uncorrectable)
      else $error("flag raised on clean word");

   // an accepted word lands in stage 1
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("accepted word lost at stage 1");

endmodule

### sv/hamming_sec_decoder.sv
// Throughput: one codeword per cycle while rsp_stall is low; the three registered
// stages (mask, syndrome XOR trees, correct and pack) each advance when the next has room.
// Reset (synchronous, active high) empties the pipeline and sets
// code_length to 7. Top level of the Hamming SEC decoder.
// Depends on hsd_pkg and hsd_pipe.
module hamming_sec_decoder
   import hsd_pkg::*;
#(
   parameter int MAX_LEN = MaxLenDef
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [CsrAddrW-1:0] paddr,
   input  logic [CsrDataW-1:0] pwdata,
   output logic [CsrDataW-1:0] prdata,
   output logic                pready,
   // codeword in
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CodeW-1:0]    req_codeword,
   // result out
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DataW-1:0]    rsp_data_bits,
   output logic [SynW-1:0]     rsp_syndrome,
   output logic                rsp_corrected,
   output logic                rsp_uncorrectable
);

   localparam logic [SynW-1:0] MaxLenC = SynW'(MAX_LEN);
   localparam logic [SynW-1:0] LenRst  = SynW'(7);

   logic [SynW-1:0] code_length_ff, code_length_in;
   logic [SynW-1:0] len_eff;
   logic            wr_en;

   // register write on the access phase
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready
                   && (paddr[CsrAddrW-1] == RegCodeLength);
   assign code_length_in = wr_en ? pwdata[SynW-1:0] : code_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff <= LenRst;
      end else begin
         code_length_ff <= code_length_in;
      end
   end

   // read back
   assign prdata = (paddr[CsrAddrW-1] == RegCodeLength)
                   ? CsrDataW'(code_length_ff) : '0;

   // clip to the configured maximum
   assign len_eff = (code_length_ff > MaxLenC) ? MaxLenC : code_length_ff;

   hsd_pipe u_pipe (
      .clock             (clock),
      .reset             (reset),
      .code_len          (len_eff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_codeword      (req_codeword),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_bits     (rsp_data_bits),
      .rsp_syndrome      (rsp_syndrome),
      .rsp_corrected     (rsp_corrected),
      .rsp_uncorrectable (rsp_uncorrectable)
   );

endmodule
